FILE: hdl/cgwt_pkg.sv
`default_nettype none
package cgwt_pkg;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned LANE_W  = 5;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned COUNT_W = 6;

  // Input item modes.
  localparam logic [MODE_W-1:0] MODE_COMMIT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WAIT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_RELEASED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SATISFIED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BLOCKED   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DONE      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEARED   = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LANE_W-1:0] lane;
    logic [WORD_W-1:0] group_tag;
    logic [WORD_W-1:0] thread_pc;
  } req_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [LANE_W-1:0]  out_lane;
    logic [WORD_W-1:0]  resume_pc;
    logic [WORD_W-1:0]  counter_value;
    logic [COUNT_W-1:0] waiting_count;
    logic               last;
  } rsp_item_t;

  // One table entry as it sits in the waiter memory.
  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic [WORD_W-1:0] group_tag;
    logic [WORD_W-1:0] resume_pc;
  } entry_t;

endpackage
`default_nettype wire

FILE: hdl/cgwt_req_if.sv
`default_nettype none
interface cgwt_req_if;
  logic                  valid;
  logic                  ready;
  cgwt_pkg::req_item_t   item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

FILE: hdl/cgwt_rsp_if.sv
`default_nettype none
interface cgwt_rsp_if;
  logic                  valid;
  logic                  ready;
  cgwt_pkg::rsp_item_t   item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

FILE: hdl/commit_group_waiter_table.sv
`default_nettype none
// Channel  Role    Item        Carries
// req      sink    req_item_t  mode, lane, group_tag, thread_pc
// rsp      source  rsp_item_t  kind, out_lane, resume_pc, counter_value, waiting_count, last
//
// A wait, clear or unused-mode item passes through the accept state and one execute
// state that produces its single result. A commit walks the single waiter memory
// (registered read) twice, with a read state and an evaluate state per entry: once to
// count releases, once to emit and compact.
// Reset (rst, synchronous) clears the counter, the fill count and the control state; the
// waiter memory itself is never cleared, only entries below the fill count are read.
// A stalled rsp holds the result in the output register; the engine waits on it only when
// it has another result to place, and req is taken again as soon as the engine is idle.
module commit_group_waiter_table #(
  parameter int unsigned MAX_WAITERS = 32,
  parameter int unsigned LANE_COUNT  = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cgwt_req_if.sink   req,
  cgwt_rsp_if.source rsp
);

  localparam int unsigned IW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned CW = $clog2(MAX_WAITERS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_CNT_RD = 3'd2;
  localparam logic [2:0] S_CNT_EV = 3'd3;
  localparam logic [2:0] S_SCN_RD = 3'd4;
  localparam logic [2:0] S_SCN_EV = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state;

  // Latched input item.
  cgwt_pkg::req_item_t cur;

  // Architectural state kept in flops.
  logic [cgwt_pkg::WORD_W-1:0] counter;
  logic [CW-1:0]               total;

  // Walk bookkeeping for a commit.
  logic [CW-1:0] idx;
  logic [CW-1:0] keep;
  logic [CW-1:0] nrel;

  // The waiter table: one entry per blocked lane, in insertion order.
  cgwt_pkg::entry_t mem [MAX_WAITERS];
  cgwt_pkg::entry_t rdata;
  logic             mem_re;
  logic             mem_we;
  logic [IW-1:0]    mem_raddr;
  logic [IW-1:0]    mem_waddr;
  cgwt_pkg::entry_t mem_wdata;

  // Output register.
  logic                rsp_valid;
  cgwt_pkg::rsp_item_t rsp_item;
  logic                out_load;
  cgwt_pkg::rsp_item_t out_next;
  logic                slot_free;

  // Decode of a wait item and of the commit walk.
  logic       bad_lane;
  logic       passes;
  logic       full;
  logic       released;
  logic       walk_end;
  logic [CW-1:0] total_after;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.item  = rsp_item;
  assign slot_free = !rsp_valid || rsp.ready;

  assign bad_lane    = (32'(cur.lane) >= LANE_COUNT);
  assign passes      = (counter >= cur.group_tag);
  assign full        = (total >= CW'(MAX_WAITERS));
  assign released    = (rdata.group_tag <= counter);
  assign walk_end    = ((idx + CW'(1)) == total);
  assign total_after = total - nrel;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx[IW-1:0];
    mem_we    = 1'b0;
    mem_waddr = keep[IW-1:0];
    mem_wdata = rdata;
    out_load  = 1'b0;
    out_next  = '0;
    out_next.counter_value = counter;
    out_next.waiting_count = cgwt_pkg::COUNT_W'(total);
    out_next.last          = 1'b1;
    case (state)
      S_EXEC: begin
        if (cur.mode != cgwt_pkg::MODE_COMMIT && slot_free) begin
          out_load = 1'b1;
          case (cur.mode)
            cgwt_pkg::MODE_WAIT: begin
              if (bad_lane) begin
                out_next.kind = cgwt_pkg::KIND_FULL;
              end else if (passes) begin
                out_next.kind = cgwt_pkg::KIND_SATISFIED;
              end else if (full) begin
                out_next.kind = cgwt_pkg::KIND_FULL;
              end else begin
                // Blocked: append the lane at the tail of the table.
                mem_we              = 1'b1;
                mem_waddr           = total[IW-1:0];
                mem_wdata.lane      = cur.lane;
                mem_wdata.group_tag = cur.group_tag;
                mem_wdata.resume_pc = cur.thread_pc + 32'd1;
                out_next.kind          = cgwt_pkg::KIND_BLOCKED;
                out_next.out_lane      = cur.lane;
                out_next.resume_pc     = cur.thread_pc + 32'd1;
                out_next.waiting_count = cgwt_pkg::COUNT_W'(total + CW'(1));
              end
            end
            cgwt_pkg::MODE_CLEAR: begin
              out_next.kind          = cgwt_pkg::KIND_CLEARED;
              out_next.counter_value = '0;
              out_next.waiting_count = '0;
            end
            default: begin
              out_next.kind = cgwt_pkg::KIND_DONE;
            end
          endcase
        end
      end
      S_CNT_RD, S_SCN_RD: begin
        mem_re = 1'b1;
      end
      S_SCN_EV: begin
        if (released) begin
          if (slot_free) begin
            out_load               = 1'b1;
            out_next.kind          = cgwt_pkg::KIND_RELEASED;
            out_next.out_lane      = rdata.lane;
            out_next.resume_pc     = rdata.resume_pc;
            out_next.waiting_count = cgwt_pkg::COUNT_W'(total_after);
            out_next.last          = 1'b0;
          end
        end else begin
          // Kept entry moves down to the compaction point; keep never passes idx.
          mem_we = 1'b1;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_next.kind = cgwt_pkg::KIND_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      counter   <= '0;
      total     <= '0;
      idx       <= '0;
      keep      <= '0;
      nrel      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cur.mode == cgwt_pkg::MODE_COMMIT) begin
            if (cur.group_tag > counter) begin
              counter <= cur.group_tag;
            end
            idx   <= '0;
            keep  <= '0;
            nrel  <= '0;
            state <= (total == '0) ? S_DONE : S_CNT_RD;
          end else if (slot_free) begin
            state <= S_IDLE;
            if (cur.mode == cgwt_pkg::MODE_CLEAR) begin
              counter <= '0;
              total   <= '0;
            end else if (cur.mode == cgwt_pkg::MODE_WAIT && !bad_lane && !passes &&
                         !full) begin
              total <= total + CW'(1);
            end
          end
        end
        S_CNT_RD: begin
          state <= S_CNT_EV;
        end
        S_CNT_EV: begin
          if (released) begin
            nrel <= nrel + CW'(1);
          end
          if (walk_end) begin
            idx   <= '0;
            state <= S_SCN_RD;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_CNT_RD;
          end
        end
        S_SCN_RD: begin
          state <= S_SCN_EV;
        end
        S_SCN_EV: begin
          if (!released || slot_free) begin
            if (!released) begin
              keep <= keep + CW'(1);
            end
            if (walk_end) begin
              total <= total_after;
              state <= S_DONE;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_SCN_RD;
            end
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cur <= req.item;
    end
    if (out_load) begin
      rsp_item <= out_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/cgwt_checker.sv
`default_nettype none
module cgwt_checker #(
  parameter int unsigned MAX_WAITERS = 32
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             rsp_valid,
  input wire logic                             rsp_ready,
  input wire logic [cgwt_pkg::KIND_W-1:0]      rsp_kind,
  input wire logic [cgwt_pkg::WORD_W-1:0]      rsp_counter,
  input wire logic [cgwt_pkg::COUNT_W-1:0]     rsp_count,
  input wire logic                             rsp_last
);

  // A result that is not taken stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp valid dropped while stalled");

  // Only released lanes are followed by more results of the same item.
  a_release_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind == cgwt_pkg::KIND_RELEASED |-> !rsp_last)
    else $error("released result marked last");

  a_other_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind != cgwt_pkg::KIND_RELEASED |-> rsp_last)
    else $error("non-release result not marked last");

  // A clear leaves nothing behind.
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind == cgwt_pkg::KIND_CLEARED |-> rsp_counter == '0 && rsp_count == '0)
    else $error("cleared result shows state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp_count) <= MAX_WAITERS || MAX_WAITERS >= 64)
    else $error("waiting count above table depth");

endmodule

bind commit_group_waiter_table cgwt_checker #(.MAX_WAITERS(MAX_WAITERS)) u_cgwt_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_kind    (rsp.item.kind),
  .rsp_counter (rsp.item.counter_value),
  .rsp_count   (rsp.item.waiting_count),
  .rsp_last    (rsp.item.last)
);
`default_nettype wire
